// File: rtl/core/kct_pkg.sv
`timescale 1ns / 1ps
package kct_pkg;
	localparam int TableEntries = 4096;
	localparam int AddrBits = $clog2(TableEntries);
	localparam int MaxBases = 32;
	localparam int KeyBits = 2 * MaxBases;
	localparam int CountBits = 32;
	localparam int LenBits = 6;

	localparam logic [2:0] CMD_ADD = 3'd0;
	localparam logic [2:0] CMD_QUERY = 3'd1;
	localparam logic [2:0] CMD_CLEAR = 3'd2;
	localparam logic [2:0] CMD_REMOVE = 3'd3;
	localparam logic [2:0] CMD_FWD = 3'd4;
	localparam logic [2:0] CMD_REV = 3'd5;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_NO_NB = 2'd3;

	typedef struct packed {
		logic                 valid;
		logic [CountBits-1:0] count;
		logic [KeyBits-1:0]   key;
	} entry_t;
endpackage

// File: rtl/core/kmer_count_table.sv
`timescale 1ns / 1ps
// one command per beat; each lookup scans the table through one memory read port,
// one entry a cycle, and a hit ends the scan early
// a neighbour command runs one such lookup for each of the four bases
// the next beat is taken once all results of the previous one sit in the output register
// after arst_n the table is cleared entry by entry, during which s_tready stays low
// config registers reset to key length 25, ds_mode 0
module kmer_count_table import kct_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,   // cmd, kmer_value, add_amount, include_zero
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,   // kmer_out, count_out
	output logic [1:0]   m_tuser,   // status
	output logic         m_tlast,   // last
	input  logic         cfg_we,
	input  logic         cfg_idx,
	input  logic [5:0]   cfg_data
);
	localparam logic [2:0] S_CLR = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_FOLD = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_ACT = 3'd4;
	localparam logic [2:0] S_PUSH = 3'd5;
	localparam logic [2:0] S_NBEND = 3'd6;

	typedef struct packed {
		logic [KeyBits-1:0]   key;
		logic [CountBits-1:0] count;
		logic [1:0]           status;
		logic                 last;
	} res_t;

	logic [LenBits-1:0]   klen_q;
	logic                 ds_q;
	logic [2:0]           state_q, ret_q;
	logic [2:0]           cmd_q;
	logic [KeyBits-1:0]   seed_q, mask_q, key_q;
	logic [CountBits-1:0] amt_q;
	logic                 zero_q;
	logic [LenBits-1:0]   k_q;
	logic [1:0]           b_q;
	logic [AddrBits:0]    ra_q;
	logic                 rv_s1;
	logic [AddrBits-1:0]  ridx_s1;
	logic                 hit_q, free_q;
	logic [AddrBits-1:0]  hidx_q, fidx_q;
	logic [CountBits-1:0] hcnt_q;
	res_t                 res_q, pend_q, out_q;
	logic                 pend_v_q, out_v_q;

	entry_t               rd, wd;
	logic                 we;
	logic [AddrBits-1:0]  wa;

	logic [LenBits-1:0]   klen_eff;
	logic [KeyBits-1:0]   in_mask, nb, fold_in, fold_v, rev, rc;
	logic [CountBits:0]   sum;
	logic [CountBits-1:0] sat, ncnt, act_cnt;
	logic [1:0]           act_st;
	logic [2:0]           nb_next;
	logic                 out_free, out_load;

	assign out_free = !out_v_q || m_tready;
	assign out_load = (state_q == S_PUSH) && out_free;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_v_q;
	assign m_tdata = {out_q.count, out_q.key};
	assign m_tuser = out_q.status;
	assign m_tlast = out_q.last;

	always_comb begin
		klen_eff = klen_q;
		if (klen_q == '0) klen_eff = LenBits'(1);
		if (klen_q > LenBits'(MaxBases)) klen_eff = LenBits'(MaxBases);
		in_mask = {KeyBits{1'b1}} >> (KeyBits - 2 * int'(klen_eff));
	end

	// neighbour key for the current base, then canonical fold of the lookup key when ds_mode is set
	always_comb begin
		if (cmd_q == CMD_FWD) nb = ((seed_q << 2) & mask_q) | KeyBits'(b_q);
		else nb = (KeyBits'(b_q) << (2 * int'(k_q) - 2)) | (seed_q >> 2);
		fold_in = (cmd_q == CMD_FWD || cmd_q == CMD_REV) ? nb : seed_q;
		fold_v = fold_in & mask_q;
		for (int i = 0; i < MaxBases; i++) begin
			rev[2*i +: 2] = fold_v[2*(MaxBases-1-i) +: 2] ^ 2'b11;
		end
		rc = rev >> (KeyBits - 2 * int'(k_q));
		if (ds_q && rc > fold_v) fold_v = rc;
	end

	assign sum = {1'b0, hcnt_q} + {1'b0, amt_q};
	assign sat = sum[CountBits] ? {CountBits{1'b1}} : sum[CountBits-1:0];
	assign ncnt = hit_q ? hcnt_q : '0;
	assign nb_next = (b_q == 2'd3) ? S_NBEND : S_FOLD;

	// result of a single-lookup command
	always_comb begin
		act_st = hit_q ? ST_OK : ST_NOT_FOUND;
		act_cnt = '0;
		if (cmd_q == CMD_ADD) begin
			act_st = (hit_q || free_q) ? ST_OK : ST_FULL;
			act_cnt = hit_q ? sat : (free_q ? amt_q : '0);
		end else if (cmd_q == CMD_QUERY) begin
			act_cnt = ncnt;
		end
	end

	// write port
	always_comb begin
		we = 1'b0;
		wa = hidx_q;
		wd = '{valid: 1'b1, count: '0, key: key_q};
		if (state_q == S_CLR) begin
			we = 1'b1;
			wa = ra_q[AddrBits-1:0];
			wd.valid = 1'b0;
		end else if (state_q == S_ACT) begin
			unique case (cmd_q)
				CMD_ADD: begin
					we = hit_q || free_q;
					wa = hit_q ? hidx_q : fidx_q;
					wd.count = hit_q ? sat : amt_q;
				end
				CMD_CLEAR: we = hit_q;
				CMD_REMOVE: begin
					we = hit_q;
					wd.valid = 1'b0;
				end
				default: we = 1'b0;
			endcase
		end
	end

	kct_table u_table (
		.clk(clk), .we(we), .wa(wa), .wd(wd), .ra(ra_q[AddrBits-1:0]), .rd(rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q <= LenBits'(25);
			ds_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_idx == 1'b0) klen_q <= cfg_data;
			else ds_q <= cfg_data[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			ret_q <= S_IDLE;
			ra_q <= '0;
			rv_s1 <= 1'b0;
			pend_v_q <= 1'b0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
		end else begin
			rv_s1 <= (state_q == S_SCAN) && !ra_q[AddrBits];
			unique case (state_q)
				S_CLR: begin
					ra_q <= ra_q + (AddrBits+1)'(1);
					if (ra_q[AddrBits-1:0] == {AddrBits{1'b1}}) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (s_tvalid) begin
						cmd_q <= s_tdata[2:0];
						seed_q <= s_tdata[66:3] & in_mask;
						mask_q <= in_mask;
						amt_q <= s_tdata[98:67];
						zero_q <= s_tdata[99];
						k_q <= klen_eff;
						b_q <= '0;
						pend_v_q <= 1'b0;
						if (s_tdata[2:0] <= CMD_REV) state_q <= S_FOLD;
					end
				end
				S_FOLD: begin
					key_q <= fold_v;
					ra_q <= '0;
					hit_q <= 1'b0;
					free_q <= 1'b0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (!ra_q[AddrBits]) begin
						ra_q <= ra_q + (AddrBits+1)'(1);
						ridx_s1 <= ra_q[AddrBits-1:0];
					end
					if (rv_s1) begin
						if (rd.valid && rd.key == key_q) begin
							hit_q <= 1'b1;
							hidx_q <= ridx_s1;
							hcnt_q <= rd.count;
							state_q <= S_ACT;
						end else begin
							if (!rd.valid && !free_q) begin
								free_q <= 1'b1;
								fidx_q <= ridx_s1;
							end
							if (ridx_s1 == {AddrBits{1'b1}}) state_q <= S_ACT;
						end
					end
				end
				S_ACT: begin
					unique case (cmd_q)
						CMD_ADD, CMD_QUERY, CMD_CLEAR, CMD_REMOVE: begin
							ret_q <= S_IDLE;
							state_q <= S_PUSH;
							res_q <= '{key: key_q, count: act_cnt, status: act_st,
								last: 1'b1};
						end
						default: begin
							// neighbour: hold one result back so the final one can carry last
							res_q <= '{key: pend_q.key, count: pend_q.count,
								status: pend_q.status, last: 1'b0};
							ret_q <= nb_next;
							b_q <= b_q + 2'd1;
							if (ncnt != '0 || zero_q) begin
								pend_q <= '{key: nb, count: ncnt, status: ST_OK, last: 1'b0};
								pend_v_q <= 1'b1;
								state_q <= pend_v_q ? S_PUSH : nb_next;
							end else begin
								state_q <= nb_next;
							end
						end
					endcase
				end
				S_NBEND: begin
					if (pend_v_q) begin
						res_q <= '{key: pend_q.key, count: pend_q.count,
							status: pend_q.status, last: 1'b1};
					end else begin
						res_q <= '{key: seed_q, count: '0, status: ST_NO_NB, last: 1'b1};
					end
					ret_q <= S_IDLE;
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					if (out_free) begin
						out_q <= res_q;
						state_q <= ret_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/core/kct_table.sv
`timescale 1ns / 1ps
module kct_table import kct_pkg::*; (
	input  logic                clk,
	input  logic                we,
	input  logic [AddrBits-1:0] wa,
	input  entry_t              wd,
	input  logic [AddrBits-1:0] ra,
	output entry_t              rd
);
	entry_t mem [TableEntries];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd <= mem[ra];
	end
endmodule
